### rtl/core/hed_pkg.sv
// Shared types, constants and character helpers for the HTML entity decoder.
package hed_pkg;

    // Characters that steer the parser
    localparam logic [7:0] C_CHAR_AMP  = 8'h26;
    localparam logic [7:0] C_CHAR_HASH = 8'h23;
    localparam logic [7:0] C_CHAR_SEMI = 8'h3B;
    localparam logic [7:0] C_CHAR_XLO  = 8'h78;
    localparam logic [7:0] C_CHAR_XUP  = 8'h58;
    localparam logic [7:0] C_CHAR_ZERO = 8'h30;

    // Result slots per input beat, held raw bytes, number of names
    localparam logic [2:0] C_MAX_RES  = 3'd5;
    localparam int         C_PEND_DEP = 4;
    localparam int         C_NAMES    = 5;
    localparam logic [2:0] C_NAME_NBSP = 3'd4;
    localparam logic [4:0] C_ALL_NAMES = 5'h1F;
    localparam logic [7:0] C_NBSP_RST  = 8'hA0;

    // Parser phase, one-hot
    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_AMP     = 10'b00_0000_0010,
        PH_HASH    = 10'b00_0000_0100,
        PH_HEXX    = 10'b00_0000_1000,
        PH_HEX1    = 10'b00_0001_0000,
        PH_DEC     = 10'b00_0010_0000,
        PH_NAME    = 10'b00_0100_0000,
        PH_SWALLOW = 10'b00_1000_0000,
        PH_SEMI    = 10'b01_0000_0000,
        PH_RAWRUN  = 10'b10_0000_0000
    } t_phase;

    // All results caused by one input beat
    typedef struct packed {
        logic [4:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
        logic            chg;
        logic            term;
    } t_desc;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (is_digit(c)) begin
            r = {1'b1, c[3:0]};
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Name spellings: quot, amp, lt, gt, nbsp
    function automatic logic [7:0] name_char(logic [2:0] k, logic [1:0] pos);
        logic [7:0] r;
        case ({k, pos})
            5'b000_00: r = 8'h71;
            5'b000_01: r = 8'h75;
            5'b000_10: r = 8'h6F;
            5'b000_11: r = 8'h74;
            5'b001_00: r = 8'h61;
            5'b001_01: r = 8'h6D;
            5'b001_10: r = 8'h70;
            5'b010_00: r = 8'h6C;
            5'b010_01: r = 8'h74;
            5'b011_00: r = 8'h67;
            5'b011_01: r = 8'h74;
            5'b100_00: r = 8'h6E;
            5'b100_01: r = 8'h62;
            5'b100_10: r = 8'h73;
            5'b100_11: r = 8'h70;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] name_len(logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0:    r = 3'd4;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Fixed byte of each name; nbsp comes from the register
    function automatic logic [7:0] name_byte(logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = 8'h22;
            3'd1:    r = 8'h26;
            3'd2:    r = 8'h3C;
            3'd3:    r = 8'h3E;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_desc desc_append(t_desc d, logic [7:0] b);
        t_desc r;
        r = d;
        if (d.cnt < C_MAX_RES) begin
            r.bytes[d.cnt] = b;
            r.cnt = d.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic t_desc desc_flush(t_desc d, logic [3:0][7:0] p, logic [2:0] n);
        t_desc r;
        r = d;
        for (int i = 0; i < C_PEND_DEP; i++) begin
            if (3'(i) < n) begin
                r = desc_append(r, p[i]);
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/hed_front.sv
// Front end: accepts one text byte per beat, parses entities, builds result descriptors.
module hed_front import hed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  logic       i_full,
    output logic       o_push,
    output t_desc      o_desc
);

    t_phase          r_phase, n_phase;
    logic [3:0][7:0] r_pend, n_pend;
    logic [2:0]      r_pc, n_pc;
    logic [7:0]      r_nv, n_nv;
    logic [1:0]      r_dc, n_dc;
    logic [4:0]      r_cand, n_cand;
    logic            r_anyd, n_anyd;
    logic [7:0]      r_nbsp;

    logic [7:0] c, lc;
    logic [4:0] hv;
    logic [4:0] cand_in, keep;
    logic [1:0] pos;
    logic       match;
    logic [2:0] match_k;
    logic       accept, redo, do_name;
    t_desc      d;

    assign c      = i_s_tdata;
    assign lc     = to_lower(c);
    assign hv     = hex_digit(c);
    assign accept = i_s_tvalid && !i_full;
    assign o_s_tready = !i_full;

    // name candidates still alive before this character, and its position in the name
    assign cand_in = (r_phase == PH_AMP) ? C_ALL_NAMES : r_cand;
    assign pos     = (r_phase == PH_AMP) ? 2'd0 : 2'(r_pc - 3'd1);

    always_comb begin
        keep    = '0;
        match   = 1'b0;
        match_k = '0;
        for (int k = 0; k < C_NAMES; k++) begin
            keep[k] = cand_in[k] && ({1'b0, pos} < name_len(3'(k)))
                      && (name_char(3'(k), pos) == lc);
        end
        for (int k = C_NAMES - 1; k >= 0; k--) begin
            if (keep[k] && (name_len(3'(k)) == 3'({1'b0, pos} + 3'd1))) begin
                match   = 1'b1;
                match_k = 3'(k);
            end
        end
    end

    // parse step for one byte
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_pc    = r_pc;
        n_nv    = r_nv;
        n_dc    = r_dc;
        n_cand  = r_cand;
        n_anyd  = r_anyd;
        d       = '0;
        redo    = 1'b0;
        do_name = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                redo = 1'b1;
            end
            PH_AMP: begin
                if (c == C_CHAR_HASH) begin
                    n_pend[1] = c;
                    n_pc      = 3'd2;
                    n_phase   = PH_HASH;
                end else if (is_alnum(c)) begin
                    n_cand  = C_ALL_NAMES;
                    do_name = 1'b1;
                end else begin
                    d    = desc_flush(d, r_pend, r_pc);
                    n_pc = '0;
                    redo = 1'b1;
                end
            end
            PH_NAME: begin
                if (is_alnum(c)) begin
                    do_name = 1'b1;
                end else begin
                    d    = desc_flush(d, r_pend, r_pc);
                    n_pc = '0;
                    redo = 1'b1;
                end
            end
            PH_HASH: begin
                if ((c == C_CHAR_XLO) || (c == C_CHAR_XUP)) begin
                    n_pend[2] = c;
                    n_pc      = 3'd3;
                    n_phase   = PH_HEXX;
                end else if (is_digit(c)) begin
                    n_nv    = c - C_CHAR_ZERO;
                    n_dc    = 2'd1;
                    n_pc    = '0;
                    n_phase = PH_DEC;
                end else begin
                    d    = desc_flush(d, r_pend, r_pc);
                    n_pc = '0;
                    redo = 1'b1;
                end
            end
            PH_HEXX: begin
                if (hv[4]) begin
                    n_nv    = {4'd0, hv[3:0]};
                    n_dc    = 2'd1;
                    n_pc    = '0;
                    n_phase = PH_HEX1;
                end else begin
                    d    = desc_flush(d, r_pend, r_pc);
                    n_pc = '0;
                    redo = 1'b1;
                end
            end
            PH_HEX1: begin
                n_anyd  = 1'b1;
                n_phase = PH_SEMI;
                if (hv[4]) begin
                    d = desc_append(d, {r_nv[3:0], hv[3:0]});
                end else begin
                    d       = desc_append(d, r_nv);
                    n_phase = PH_IDLE;
                    redo    = (c != C_CHAR_SEMI);
                end
            end
            PH_DEC: begin
                if (is_digit(c)) begin
                    // value * 10 + digit, wrapping at 8 bits
                    n_nv = {r_nv[4:0], 3'b000} + {r_nv[6:0], 1'b0} + (c - C_CHAR_ZERO);
                    n_dc = r_dc + 2'd1;
                    if ((n_dc == 2'd3) || (n_dc == 2'd0)) begin
                        d       = desc_append(d, n_nv);
                        n_anyd  = 1'b1;
                        n_phase = PH_SEMI;
                    end
                end else begin
                    d       = desc_append(d, r_nv);
                    n_anyd  = 1'b1;
                    n_phase = PH_IDLE;
                    redo    = (c != C_CHAR_SEMI);
                end
            end
            PH_SEMI: begin
                n_phase = PH_IDLE;
                redo    = (c != C_CHAR_SEMI);
            end
            PH_SWALLOW: begin
                if (!is_alnum(c)) begin
                    n_phase = PH_IDLE;
                    redo    = (c != C_CHAR_SEMI);
                end
            end
            PH_RAWRUN: begin
                if (is_alnum(c)) begin
                    d = desc_append(d, c);
                end else begin
                    redo = 1'b1;
                end
            end
            default: begin
                redo = 1'b1;
            end
        endcase

        // one character of a name prefix
        if (do_name) begin
            if (match) begin
                d       = desc_append(d, (match_k == C_NAME_NBSP) ? r_nbsp
                                                                  : name_byte(match_k));
                n_anyd  = 1'b1;
                n_pc    = '0;
                n_phase = PH_SWALLOW;
            end else if (keep == '0) begin
                d       = desc_flush(d, r_pend, r_pc);
                d       = desc_append(d, c);
                n_pc    = '0;
                n_phase = PH_RAWRUN;
            end else begin
                n_cand            = keep;
                n_pend[r_pc[1:0]] = c;
                n_pc              = r_pc + 3'd1;
                n_phase           = PH_NAME;
            end
        end

        // byte handled afresh from idle
        if (redo) begin
            n_phase = PH_IDLE;
            if (c == C_CHAR_AMP) begin
                n_pend[0] = c;
                n_pc      = 3'd1;
                n_phase   = PH_AMP;
            end else begin
                d = desc_append(d, c);
            end
        end

        // end of text: drain what is held, then back to reset state
        if (i_s_tlast) begin
            case (n_phase)
                PH_AMP, PH_HASH, PH_HEXX, PH_NAME: begin
                    d = desc_flush(d, n_pend, n_pc);
                end
                PH_HEX1, PH_DEC: begin
                    d      = desc_append(d, n_nv);
                    n_anyd = 1'b1;
                end
                default: begin
                end
            endcase
            d.last = 1'b1;
            d.chg  = n_anyd;
            if (d.cnt == '0) begin
                d.term = 1'b1;
                d.cnt  = 3'd1;
            end
            n_phase = PH_IDLE;
            n_pc    = '0;
            n_nv    = '0;
            n_dc    = '0;
            n_cand  = C_ALL_NAMES;
            n_anyd  = 1'b0;
        end
    end

    assign o_push = accept && (d.cnt != '0);
    assign o_desc = d;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pc    <= '0;
            r_nv    <= '0;
            r_dc    <= '0;
            r_cand  <= C_ALL_NAMES;
            r_anyd  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_nv    <= n_nv;
            r_dc    <= n_dc;
            r_cand  <= n_cand;
            r_anyd  <= n_anyd;
        end
    end

    // held raw bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    // nbsp register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbsp <= C_NBSP_RST;
        end else if (i_cfg_valid) begin
            r_nbsp <= i_cfg_data;
        end
    end

endmodule

### rtl/core/hed_queue.sv
// Descriptor queue between the parsing front end and the output serialiser.
module hed_queue import hed_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

### rtl/core/hed_back.sv
// Back end: serialises each descriptor into result beats through an output register.
module hed_back import hed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_desc       i_desc,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_outv, r_run, r_stream, r_chg;
    logic       load, final_res;

    assign load      = !i_empty && (!r_valid || i_m_tready);
    assign final_res = (r_idx == (i_desc.cnt - 3'd1));
    assign o_pop     = load && final_res;

    // beat index within the head descriptor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= final_res ? '0 : r_idx + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= i_desc.bytes[r_idx];
            r_outv   <= !i_desc.term;
            r_run    <= final_res;
            r_stream <= final_res && i_desc.last;
            r_chg    <= final_res && i_desc.last && i_desc.chg;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_chg, r_run, r_byte};
    assign o_m_tlast  = r_stream;
    assign o_m_tuser  = r_outv;

endmodule

### rtl/core/html_entity_decoder.sv
// Top level of the HTML entity decoder: parser, descriptor queue, serialiser.
// A result passes from its input beat through the queue memory and the output register.
// Throughput: one input byte per cycle while the queue has room; one result per cycle
// out while i_m_tready is high, set by the single-beat output register, so an entity
// flush of up to 5 bytes is absorbed by the queue. Synchronous active-low reset returns
// the parser to idle, empties the queue and loads nbsp_value with 0xA0.
module html_entity_decoder import hed_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [8] run_end, [9] changed, rest zero
    output logic        o_m_tlast,
    output logic [0:0]  o_m_tuser    // [0] out_valid
);

    logic  push, pop, full, empty;
    t_desc wr_desc, rd_desc;

    assign o_cfg_ready = 1'b1;

    hed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_desc      (wr_desc)
    );

    hed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (wr_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_desc  (rd_desc)
    );

    hed_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_desc     (rd_desc),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
